/* rtl/sparse_negacyclic_poly_mul_defines.svh */
// Assertion macros shared by the checker of the sparse negacyclic multiplier.
`ifndef SPARSE_NEGACYCLIC_POLY_MUL_DEFINES_SVH
`define SPARSE_NEGACYCLIC_POLY_MUL_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define SNPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same check, but it stays armed while reset is asserted.
`define SNPM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/snpm_pkg.sv */
// Shared types and constants of the sparse negacyclic polynomial multiplier.
package snpm_pkg;

  localparam int DEGREE_DEF    = 1024;
  localparam int COEF_BITS_DEF = 32;
  localparam int IDX_W         = 10;
  localparam int VAL_W         = 32;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TERM  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_REDUCE,
    ST_TERM,
    ST_CLEAR,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_src;
    logic cnt_clr;
    logic cnt_inc;
    logic zero_wr;
    logic term_rd;
    logic pos_fold;
    logic prod_rd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic pos_big;
    logic cnt_last;
  } status_t;

endpackage

/* rtl/snpm_ctrl.sv */
// Control state machine: sequences reset clearing, loads, terms, clears and reads.
module snpm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_type,
  input  logic                res_stall,
  input  snpm_pkg::status_t   status,
  output snpm_pkg::cmd_t      cmd,
  output logic                req_stall,
  output logic                res_valid
);

  snpm_pkg::state_t state;
  snpm_pkg::state_t state_next;
  logic             res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= snpm_pkg::ST_INIT;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snpm_pkg::ST_INIT: begin
        if (status.cnt_last) state_next = snpm_pkg::ST_IDLE;
      end
      snpm_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (snpm_pkg::req_t'(req_type))
            snpm_pkg::REQ_LOAD:  state_next = snpm_pkg::ST_IDLE;
            snpm_pkg::REQ_TERM:  state_next = snpm_pkg::ST_REDUCE;
            snpm_pkg::REQ_CLEAR: state_next = snpm_pkg::ST_CLEAR;
            snpm_pkg::REQ_READ:  state_next = snpm_pkg::ST_READ;
            default:             state_next = snpm_pkg::ST_IDLE;
          endcase
        end
      end
      snpm_pkg::ST_REDUCE: begin
        if (!status.pos_big) state_next = snpm_pkg::ST_TERM;
      end
      snpm_pkg::ST_TERM: begin
        if (status.cnt_last) state_next = snpm_pkg::ST_IDLE;
      end
      snpm_pkg::ST_CLEAR: begin
        if (status.cnt_last) state_next = snpm_pkg::ST_IDLE;
      end
      snpm_pkg::ST_READ: begin
        state_next = snpm_pkg::ST_RESULT;
      end
      snpm_pkg::ST_RESULT: begin
        if (!res_valid || !res_stall) state_next = snpm_pkg::ST_IDLE;
      end
      default: state_next = snpm_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      snpm_pkg::ST_INIT: begin
        cmd.zero_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      snpm_pkg::ST_IDLE: begin
        cmd.capture  = 1'b1;
        cmd.cnt_clr  = req_valid;
        cmd.load_src = req_valid && (req_type == snpm_pkg::REQ_LOAD);
      end
      snpm_pkg::ST_REDUCE: begin
        cmd.pos_fold = status.pos_big;
      end
      snpm_pkg::ST_TERM: begin
        cmd.term_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      snpm_pkg::ST_CLEAR: begin
        cmd.zero_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      snpm_pkg::ST_READ: begin
        cmd.prod_rd = 1'b1;
      end
      snpm_pkg::ST_RESULT: begin
        cmd.res_load = !res_valid || !res_stall;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  assign req_stall = (state != snpm_pkg::ST_IDLE);

endmodule

/* rtl/snpm_datapath.sv */
// Datapath: source and product memories, index counter and the accumulate stage.
module snpm_datapath #(
  parameter int DEGREE    = snpm_pkg::DEGREE_DEF,
  parameter int COEF_BITS = snpm_pkg::COEF_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  snpm_pkg::cmd_t                     cmd,
  input  logic [snpm_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [snpm_pkg::VAL_W-1:0]  coef_value,
  input  logic [snpm_pkg::IDX_W-1:0]         term_position,
  input  logic                               term_negative,
  output snpm_pkg::status_t                  status,
  output logic [snpm_pkg::IDX_W-1:0]         product_index,
  output logic signed [snpm_pkg::VAL_W-1:0]  product_value
);

  localparam int AW = (DEGREE > 1) ? $clog2(DEGREE) : 1;
  localparam int IW = snpm_pkg::IDX_W;
  localparam int VW = snpm_pkg::VAL_W;

  logic [COEF_BITS-1:0] src_mem [DEGREE];
  logic [VW-1:0]        prod_mem [DEGREE];

  logic [AW-1:0]              cnt;
  logic [IW-1:0]              req_idx;
  logic [IW-1:0]              pos;
  logic                       neg;
  logic                       idx_ok;
  logic signed [COEF_BITS-1:0] src_rd;
  logic [VW-1:0]              prod_rd_q;
  logic                       wr_pending;
  logic [AW-1:0]              wr_addr;
  logic                       wr_sub;

  logic [AW-1:0] shift;
  logic          below;
  logic [AW-1:0] src_addr;
  logic [VW-1:0] src_ext;
  logic [VW-1:0] acc;
  logic          prod_we;
  logic [AW-1:0] prod_waddr;
  logic [VW-1:0] prod_wdata;
  logic [AW-1:0] prod_raddr;
  logic          load_ok;

  // The position is already reduced below DEGREE when a term runs.
  assign shift    = AW'(pos);
  assign below    = (cnt < shift);
  assign src_addr = below ? (cnt - shift + AW'(DEGREE)) : (cnt - shift);
  assign src_ext  = VW'(src_rd);
  assign acc      = wr_sub ? (prod_rd_q - src_ext) : (prod_rd_q + src_ext);
  assign load_ok  = (32'(coef_index) < DEGREE);

  assign status.pos_big  = (32'(pos) >= DEGREE);
  assign status.cnt_last = (cnt == AW'(DEGREE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      wr_pending <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      wr_pending <= cmd.term_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_idx <= coef_index;
      pos     <= term_position;
      neg     <= term_negative;
      idx_ok  <= load_ok;
    end else if (cmd.pos_fold) begin
      // X^DEGREE equals -1, so each fold flips the sign.
      pos <= pos - IW'(DEGREE);
      neg <= !neg;
    end
    wr_addr <= cnt;
    wr_sub  <= neg ^ below;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_src && load_ok) begin
      src_mem[AW'(coef_index)] <= coef_value[COEF_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term_rd) begin
      src_rd <= src_mem[src_addr];
    end
  end

  // One write port shared by the clearing sweep and the accumulate stage.
  always_comb begin
    prod_we    = cmd.zero_wr || wr_pending;
    prod_waddr = cmd.zero_wr ? cnt : wr_addr;
    prod_wdata = cmd.zero_wr ? '0 : acc;
    prod_raddr = cmd.term_rd ? cnt : AW'(req_idx);
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_waddr] <= prod_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term_rd || cmd.prod_rd) begin
      prod_rd_q <= prod_mem[prod_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      product_index <= req_idx;
      product_value <= idx_ok ? prod_rd_q : '0;
    end
  end

endmodule

/* rtl/sparse_negacyclic_poly_mul.sv */
// Top level of the sparse negacyclic polynomial multiplier.
//
//   channel  | handshake             | payload
//   request  | req_valid, req_stall  | req_type, coef_index, coef_value,
//            |                       | term_position, term_negative
//   result   | res_valid, res_stall  | product_index, product_value
//
// A load is taken while the block stays idle. A clear sweeps the product
// memory to zero. A term first folds term_position below DEGREE, then the
// product memory port handles one coefficient per cycle. A read waits for
// the result register to empty. After reset the product memory is swept to
// zero, with req_stall high. A stalled result beat does not hold up loads,
// terms or clears.
module sparse_negacyclic_poly_mul #(
  parameter int DEGREE    = snpm_pkg::DEGREE_DEF,
  parameter int COEF_BITS = snpm_pkg::COEF_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic [snpm_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [snpm_pkg::VAL_W-1:0]  coef_value,
  input  logic [snpm_pkg::IDX_W-1:0]         term_position,
  input  logic                               term_negative,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [snpm_pkg::IDX_W-1:0]         product_index,
  output logic signed [snpm_pkg::VAL_W-1:0]  product_value
);

  snpm_pkg::cmd_t    cmd;
  snpm_pkg::status_t status;

  snpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd),
    .req_stall (req_stall),
    .res_valid (res_valid)
  );

  snpm_datapath #(
    .DEGREE    (DEGREE),
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .term_position (term_position),
    .term_negative (term_negative),
    .status        (status),
    .product_index (product_index),
    .product_value (product_value)
  );

endmodule

/* rtl/snpm_checker.sv */
// Port-level checks of the sparse negacyclic multiplier, bound to the top level.
`include "sparse_negacyclic_poly_mul_defines.svh"

module snpm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_stall,
  input logic [1:0]                         req_type,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic [snpm_pkg::IDX_W-1:0]         product_index,
  input logic signed [snpm_pkg::VAL_W-1:0]  product_value
);

  `SNPM_ASSERT_NEXT(a_res_held, clk, rst, res_valid && res_stall, res_valid, "result beat dropped while stalled")
  `SNPM_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(product_value) && $stable(product_index), "stalled result beat changed")
  `SNPM_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall && (req_type != snpm_pkg::REQ_LOAD), req_stall, "request taken while a multi-cycle request runs")
  `SNPM_ASSERT_NEXT_ALWAYS(a_busy_after_reset, clk, rst, req_stall, "request taken during the clearing sweep")

endmodule

bind sparse_negacyclic_poly_mul snpm_checker u_checker (.*);
